// File: rtl/core/pte_pkg.sv
package pte_pkg;

  localparam int CntW           = 7;
  localparam int RateW          = 16;
  localparam int LvlW           = 32;
  localparam int PktW           = 6;
  localparam int ProdW          = 48;
  localparam int MaxPacketsDef  = 64;
  localparam int ApbAddrW       = 5;
  localparam int ApbDataW       = 32;

  // register index, paddr[4:2]
  localparam logic [2:0] REG_PKT_CNT  = 3'd0;
  localparam logic [2:0] REG_EVAP     = 3'd1;
  localparam logic [2:0] REG_INIT     = 3'd2;
  localparam logic [2:0] REG_CLAMP_EN = 3'd3;
  localparam logic [2:0] REG_FLOOR    = 3'd4;
  localparam logic [2:0] REG_CEIL     = 3'd5;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_EVAP  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [PktW-1:0]   row_packet;
    logic [PktW-1:0]   col_packet;
    logic              row_orient;
    logic              col_orient;
    logic [LvlW-1:0]   write_level;
  } cmd_t;

  typedef struct packed {
    logic [LvlW-1:0]   read_level;
    logic              done_res;
  } res_t;

  // floor first, then ceiling: floor above ceiling yields ceiling
  function automatic logic [LvlW-1:0] bound_level(input logic [LvlW-1:0] v,
                                                  input logic            en,
                                                  input logic [LvlW-1:0] lo,
                                                  input logic [LvlW-1:0] hi);
    logic [LvlW-1:0] t;
    t = v;
    if (en) begin
      if (t <= lo) t = lo;
      if (t >= hi) t = hi;
    end
    return t;
  endfunction

endpackage

// File: rtl/core/pheromone_table_engine_top.sv
// Pheromone table engine: ant-colony level table indexed by
// (row packet, column packet, row orientation, column orientation).
//
// Command channel: a transaction is taken when start is high and busy low.
// Result channel: done_o pulses for one cycle with res_o; the receiver
// cannot stall, so every result is taken in the cycle it is shown.
// Config: APB-style, 6 registers at 4-byte steps, pready always high.
//
// Sequence, start accepted to done_o:
//   read / write : one registered RAM read, then result
//   init         : sweep of 4*n*n entries, then result
//   evaporate    : sweep of 4*n*n entries, then result
// with n = min(packet_count, MAX_PACKETS). Sweeps cost one entry per cycle,
// set by the single RAM write port; evaporate runs read -> multiply ->
// clamp/write through the 32x17 multiplier, and that pipelined tail
// drains while the closing diagonal entries (skipped) are swept.
// busy stays high for the whole transaction; the next one can be taken in
// the cycle done_o is high.
// Reset clears control and config registers only; the table contents are
// undefined until written by write or init. No clearing pass is run.
module pheromone_table_engine_top
  import pte_pkg::*;
#(
  parameter int MAX_PACKETS = pte_pkg::MaxPacketsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  pte_pkg::cmd_t           cmd_i,
  // result channel
  output logic                    done_o,
  output pte_pkg::res_t           res_o,
  // config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [pte_pkg::ApbAddrW-1:0] paddr,
  input  logic [pte_pkg::ApbDataW-1:0] pwdata,
  output logic [pte_pkg::ApbDataW-1:0] prdata,
  output logic                    pready
);

  localparam int PW = $clog2(MAX_PACKETS);
  localparam int AW = 2 * PW + 2;
  localparam int Depth = 2 ** AW;
  localparam int NW = (CntW > PW + 1) ? CntW : PW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DRAIN
  } state_e;

  // ---------------- config registers ----------------
  logic [CntW-1:0]  pkt_cnt_q;
  logic [RateW-1:0] evap_rate_q;
  logic [LvlW-1:0]  init_lvl_q;
  logic             clamp_en_q;
  logic [LvlW-1:0]  floor_q;
  logic [LvlW-1:0]  ceil_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q   <= CntW'(64);
      evap_rate_q <= RateW'(6554);
      init_lvl_q  <= LvlW'(65536);
      clamp_en_q  <= 1'b0;
      floor_q     <= '0;
      ceil_q      <= '1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_PKT_CNT:  pkt_cnt_q   <= pwdata[CntW-1:0];
        REG_EVAP:     evap_rate_q <= pwdata[RateW-1:0];
        REG_INIT:     init_lvl_q  <= pwdata[LvlW-1:0];
        REG_CLAMP_EN: clamp_en_q  <= pwdata[0];
        REG_FLOOR:    floor_q     <= pwdata[LvlW-1:0];
        REG_CEIL:     ceil_q      <= pwdata[LvlW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PKT_CNT:  prdata = ApbDataW'(pkt_cnt_q);
      REG_EVAP:     prdata = ApbDataW'(evap_rate_q);
      REG_INIT:     prdata = init_lvl_q;
      REG_CLAMP_EN: prdata = ApbDataW'(clamp_en_q);
      REG_FLOOR:    prdata = floor_q;
      REG_CEIL:     prdata = ceil_q;
      default:      prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  state_e          state_q;
  cmd_t            item_q;
  logic [PW-1:0]   i_q, j_q;
  logic [1:0]      e_q;
  logic            s1_vld_q, s2_vld_q;
  logic [AW-1:0]   s1_addr_q, s2_addr_q;
  logic [LvlW-1:0] rd_q;
  logic [ProdW-1:0] prod_q;
  logic            done_q;
  res_t            res_q;

  logic [LvlW-1:0] mem [Depth];

  logic [NW-1:0]   n_eff;
  logic [PW:0]     n_m1;
  logic            in_range;
  logic            accept;
  logic            diag, j_last, i_last;
  logic [AW-1:0]   in_addr, item_addr, sw_addr, rd_addr, wr_addr;
  logic            wr_en;
  logic [LvlW-1:0] wr_data;
  logic [RateW:0]  keep;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // packets in use, limited to the table size
  assign n_eff = (32'(pkt_cnt_q) < MAX_PACKETS) ? NW'(pkt_cnt_q) : NW'(MAX_PACKETS);
  assign n_m1  = (PW+1)'(n_eff) - (PW+1)'(1);
  assign in_range = (NW'(item_q.row_packet) < n_eff) &&
                    (NW'(item_q.col_packet) < n_eff);

  assign in_addr   = {PW'(cmd_i.row_packet), PW'(cmd_i.col_packet),
                      cmd_i.row_orient, cmd_i.col_orient};
  assign item_addr = {PW'(item_q.row_packet), PW'(item_q.col_packet),
                      item_q.row_orient, item_q.col_orient};
  assign sw_addr   = {i_q, j_q, e_q};
  assign rd_addr   = (state_q == S_SWEEP) ? sw_addr : in_addr;

  assign diag   = (i_q == j_q);
  assign j_last = ({1'b0, j_q} == n_m1);
  assign i_last = ({1'b0, i_q} == n_m1);
  assign keep   = (RateW+1)'(65536) - {1'b0, evap_rate_q};

  // single write port: evaporate tail, init sweep, or plain write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_addr;
    wr_data = bound_level(item_q.write_level, clamp_en_q, floor_q, ceil_q);
    if (s2_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = s2_addr_q;
      wr_data = bound_level(prod_q[ProdW-1:RateW], clamp_en_q, floor_q, ceil_q);
    end else if (state_q == S_SWEEP && item_q.command == CMD_INIT) begin
      wr_en   = 1'b1;
      wr_addr = sw_addr;
      wr_data = bound_level(diag ? '0 : init_lvl_q, clamp_en_q, floor_q, ceil_q);
    end else if (state_q == S_EXEC && item_q.command == CMD_WRITE && in_range) begin
      wr_en   = 1'b1;
    end
  end

  // table RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // datapath registers (no reset)
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= cmd_i;
    s1_addr_q <= sw_addr;
    s2_addr_q <= s1_addr_q;
    prod_q    <= {16'b0, rd_q} * {31'b0, keep};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      e_q      <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      done_q   <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= s1_vld_q;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            i_q <= '0;
            j_q <= '0;
            e_q <= '0;
            if (cmd_i.command == CMD_READ || cmd_i.command == CMD_WRITE) begin
              state_q <= S_EXEC;
            end else if (n_eff == '0) begin
              state_q <= S_DRAIN;
            end else begin
              state_q <= S_SWEEP;
            end
          end
        end
        S_EXEC: begin
          done_q         <= 1'b1;
          res_q.done_res <= 1'b1;
          res_q.read_level <= (item_q.command == CMD_READ && in_range) ? rd_q : '0;
          state_q        <= S_IDLE;
        end
        S_SWEEP: begin
          // diagonal entries are skipped by evaporate
          s1_vld_q <= (item_q.command == CMD_EVAP) && !diag;
          e_q <= e_q + 2'd1;
          if (e_q == 2'd3) begin
            if (j_last) begin
              j_q <= '0;
              i_q <= i_q + PW'(1);
              if (i_last) state_q <= S_DRAIN;
            end else begin
              j_q <= j_q + PW'(1);
            end
          end
        end
        S_DRAIN: begin
          if (!s1_vld_q && !s2_vld_q) begin
            done_q           <= 1'b1;
            res_q.done_res   <= 1'b1;
            res_q.read_level <= '0;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("done without a transaction in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_evap_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> busy && !done_o)
    else $error("evaporate write outside its sweep");

  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && item_q.command != CMD_READ |-> res_o.read_level == '0)
    else $error("non-read transaction returned a level");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
  import pte_pkg::*;

  localparam int MaxPackets = pte_pkg::MaxPacketsDef;
  localparam int TableDepth = MaxPackets * MaxPackets * 4;
  // Full-table sweeps are kept to a handful, and random sweeps only run with
  // at most 8 packets.
  localparam int CycleLimit = 1_000_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // command channel
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;

  // result channel
  logic done_o;
  res_t res_o;

  // config port
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  pheromone_table_engine_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------
  // Mirror of the level table and of the config registers.
  // Config only changes while the block is idle, so the mirror is updated
  // straight from the config write task.
  // --------------------------------------------------------------------
  logic [LvlW-1:0]  level_mirror [TableDepth];
  logic [CntW-1:0]  cfg_pkt_cnt  = 7'd64;
  logic [RateW-1:0] cfg_rate     = 16'd6554;
  logic [LvlW-1:0]  cfg_init_lvl = 32'h0001_0000;
  logic             cfg_clamp    = 1'b0;
  logic [LvlW-1:0]  cfg_floor    = 32'h0000_0000;
  logic [LvlW-1:0]  cfg_ceil     = 32'hFFFF_FFFF;

  cmd_t pending_cmds [$];   // transactions not yet offered
  res_t due_replies  [$];   // predicted results, oldest first

  int  sender_idle_pct = 0;
  int  fail_count      = 0;
  int  cycle_count     = 0;
  logic cmd_taken      = 1'b0;

  function automatic int live_packets();
    return (cfg_pkt_cnt < MaxPackets) ? int'(cfg_pkt_cnt) : MaxPackets;
  endfunction

  // clamp applied to every stored level; floor first, then ceiling, so ceiling wins
  function automatic logic [LvlW-1:0] clamp_stored(logic [LvlW-1:0] v);
    logic [LvlW-1:0] s;
    s = v;
    if (cfg_clamp) begin
      if (s <= cfg_floor) s = cfg_floor;
      if (s >= cfg_ceil)  s = cfg_ceil;
    end
    return s;
  endfunction

  // Table update for one accepted transaction; returns the predicted result.
  function automatic res_t apply_table_cmd(cmd_t item);
    res_t            reply;
    int              n;
    logic [16:0]     keep;
    logic [48:0]     product;
    logic [13:0]     k;
    logic            hit;
    n   = live_packets();
    hit = (int'(item.row_packet) < n) && (int'(item.col_packet) < n);
    k   = {item.row_packet, item.col_packet, item.row_orient, item.col_orient};
    reply.read_level = '0;
    reply.done_res   = 1'b1;
    case (item.command)
      CMD_READ: begin
        if (hit) reply.read_level = level_mirror[k];
      end
      CMD_WRITE: begin
        if (hit) level_mirror[k] = clamp_stored(item.write_level);
      end
      CMD_EVAP: begin
        keep = 17'd65536 - cfg_rate;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            if (i != j)
              for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++) begin
                  k = {i[5:0], j[5:0], a[0], b[0]};
                  product = level_mirror[k] * keep;
                  // truncated Q16.16 x Q1.16 product, never above the old level
                  level_mirror[k] = clamp_stored(product[47:16]);
                end
      end
      default: begin  // CMD_INIT: diagonal gets zero, clamped like any store
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            for (int a = 0; a < 2; a++)
              for (int b = 0; b < 2; b++) begin
                k = {i[5:0], j[5:0], a[0], b[0]};
                level_mirror[k] = clamp_stored((i == j) ? '0 : cfg_init_lvl);
              end
      end
    endcase
    return reply;
  endfunction

  // --------------------------------------------------------------------
  // Driver: offers the next transaction on the falling edge once the
  // previous one was taken; start holds steady until start && !busy.
  // --------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        cmd_i <= pending_cmds.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------
  // Monitor: results are checked before the transaction accepted on the
  // same edge is predicted, so a result can never match its own request.
  // --------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= start && !busy;
      if (done_o) begin
        if (due_replies.size() == 0) begin
          $error("result with nothing pending: read_level %h", res_o.read_level);
          fail_count++;
        end else begin
          want = due_replies.pop_front();
          if (res_o.read_level !== want.read_level) begin
            $error("read_level: expected %h, got %h", want.read_level, res_o.read_level);
            fail_count++;
          end
          if (res_o.done_res !== want.done_res) begin
            $error("done_res: expected %b, got %b", want.done_res, res_o.done_res);
            fail_count++;
          end
        end
      end
      if (start && !busy) due_replies = {due_replies, apply_table_cmd(cmd_i)};
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------
  function automatic void queue_cmd(cmd_e op, int r, int c, int ro, int co,
                                    logic [LvlW-1:0] lvl);
    cmd_t item;
    item.command     = op;
    item.row_packet  = r[PktW-1:0];
    item.col_packet  = c[PktW-1:0];
    item.row_orient  = ro[0];
    item.col_orient  = co[0];
    item.write_level = lvl;
    pending_cmds = {pending_cmds, item};
  endfunction

  // APB write with setup and access phases; mirror follows once the access phase completes.
  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PKT_CNT:  cfg_pkt_cnt  = val[CntW-1:0];
      REG_EVAP:     cfg_rate     = val[RateW-1:0];
      REG_INIT:     cfg_init_lvl = val;
      REG_CLAMP_EN: cfg_clamp    = val[0];
      REG_FLOOR:    cfg_floor    = val;
      REG_CEIL:     cfg_ceil     = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every transaction is taken and every result is in
  task automatic drain();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || start || due_replies.size() != 0 || busy);
  endtask

  // Random transactions. Mostly in-range reads and writes so that data paths
  // and clamping get exercised; some out-of-range noise. Sweeps only when
  // the table in use is small.
  task automatic queue_random(int count, bit sweeps_ok);
    int              roll, n, r, c;
    cmd_e            op;
    logic [LvlW-1:0] lvl;
    n = live_packets();
    for (int idx = 0; idx < count; idx++) begin
      roll = $urandom_range(99);
      if (sweeps_ok && roll < 8)       op = CMD_INIT;
      else if (sweeps_ok && roll < 20) op = CMD_EVAP;
      else if (roll < 58)              op = CMD_READ;
      else                             op = CMD_WRITE;
      if (n > 0 && $urandom_range(99) < 85) begin
        r = $urandom_range(n - 1);
        c = ($urandom_range(3) == 0) ? r : $urandom_range(n - 1);
      end else begin
        r = $urandom_range(63);
        c = $urandom_range(63);
      end
      case ($urandom_range(7))
        0: lvl = cfg_floor;
        1: lvl = cfg_ceil;
        2: lvl = cfg_floor - 1;
        3: lvl = cfg_ceil + 1;
        4: lvl = 32'h0;
        5: lvl = 32'hFFFF_FFFF;
        6: lvl = $urandom_range(32'h0003_0000);
        default: lvl = $urandom;
      endcase
      queue_cmd(op, r, c, $urandom_range(1), $urandom_range(1), lvl);
    end
  endtask

  // --------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------
  initial begin : stimulus
    int              pc, n;
    logic [LvlW-1:0] lo, hi, init_lvl;
    logic [RateW-1:0] rate;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config (64 packets). The first init writes the whole table, so
    // no later read can land on an entry that was never written.
    queue_cmd(CMD_INIT,  0,  0,  0, 0, 32'h0);
    queue_cmd(CMD_READ,  0,  0,  0, 0, 32'h0);             // diagonal: zero
    queue_cmd(CMD_READ,  63, 62, 1, 1, 32'h0);
    queue_cmd(CMD_WRITE, 63, 0,  1, 0, 32'hFFFF_FFFF);
    queue_cmd(CMD_READ,  63, 0,  1, 0, 32'h0);
    queue_cmd(CMD_WRITE, 0,  63, 0, 1, 32'h0);
    queue_cmd(CMD_EVAP,  0,  0,  0, 0, 32'h0);
    queue_cmd(CMD_READ,  63, 0,  1, 0, 32'h0);             // truncated product
    queue_cmd(CMD_READ,  0,  63, 0, 1, 32'h0);
    drain();

    // no packets in use: sweeps are no-ops, reads/writes fall outside
    apb_write(REG_PKT_CNT, 32'd0);
    queue_cmd(CMD_INIT,  0, 0, 0, 0, 32'h0);
    queue_cmd(CMD_EVAP,  0, 0, 0, 0, 32'h0);
    queue_cmd(CMD_READ,  0, 0, 0, 0, 32'h0);
    queue_cmd(CMD_WRITE, 0, 1, 1, 1, 32'h1234_5678);
    drain();

    // count above MAX_PACKETS, floor above ceiling: stores land on ceiling
    apb_write(REG_PKT_CNT,  32'd127);
    apb_write(REG_CLAMP_EN, 32'd1);
    apb_write(REG_FLOOR,    32'h0002_0000);
    apb_write(REG_CEIL,     32'h0001_0000);
    apb_write(REG_EVAP,     32'd65535);
    apb_write(REG_INIT,     32'hFFFF_FFFF);
    queue_cmd(CMD_WRITE, 63, 1,  1, 1, 32'h5);
    queue_cmd(CMD_READ,  63, 1,  1, 1, 32'h0);
    queue_cmd(CMD_WRITE, 62, 63, 0, 1, 32'hFFFF_FFFF);
    queue_cmd(CMD_READ,  62, 63, 0, 1, 32'h0);
    drain();

    // small table, ordinary clamp window; values right on the bounds
    apb_write(REG_PKT_CNT, 32'd3);
    apb_write(REG_FLOOR,   32'd100);
    apb_write(REG_CEIL,    32'hFFFF_0000);
    queue_cmd(CMD_INIT,  0, 0, 0, 0, 32'h0);
    queue_cmd(CMD_READ,  2, 2, 1, 0, 32'h0);               // clamped zero
    queue_cmd(CMD_EVAP,  0, 0, 0, 0, 32'h0);               // maximal rate
    queue_cmd(CMD_READ,  0, 2, 1, 1, 32'h0);
    queue_cmd(CMD_WRITE, 1, 0, 0, 0, 32'd100);
    queue_cmd(CMD_READ,  1, 0, 0, 0, 32'h0);
    queue_cmd(CMD_WRITE, 2, 1, 1, 1, 32'hFFFF_0000);
    drain();

    // zero rate: evaporation leaves the table unchanged
    apb_write(REG_EVAP,     32'd0);
    apb_write(REG_CLAMP_EN, 32'd0);
    queue_cmd(CMD_EVAP, 0, 0, 0, 0, 32'h0);
    queue_cmd(CMD_READ, 2, 1, 1, 1, 32'h0);
    drain();

    // Random phases, each with its own config and sender idle rate.
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(9))
        0:       pc = 0;
        1:       pc = 64;
        2:       pc = 127;
        3:       pc = $urandom_range(9, 63);
        default: pc = $urandom_range(1, 8);
      endcase
      case ($urandom_range(3))
        0:       rate = 16'd0;
        1:       rate = 16'hFFFF;
        default: rate = 16'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(3))
        0:       init_lvl = 32'h0;
        1:       init_lvl = 32'hFFFF_FFFF;
        default: init_lvl = $urandom_range(32'h0008_0000);
      endcase
      case ($urandom_range(4))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin
          lo = 32'h0;
          hi = 32'hFFFF_FFFF;
        end
        2: begin  // inverted window
          hi = $urandom_range(32'h0004_0000);
          lo = hi + $urandom_range(1, 32'h0001_0000);
        end
        default: begin
          lo = $urandom_range(32'h0002_0000);
          hi = lo + $urandom_range(32'h0004_0000);
        end
      endcase
      apb_write(REG_PKT_CNT,  pc);
      apb_write(REG_EVAP,     32'(rate));
      apb_write(REG_INIT,     init_lvl);
      apb_write(REG_CLAMP_EN, $urandom_range(1));
      apb_write(REG_FLOOR,    lo);
      apb_write(REG_CEIL,     hi);
      case (phase % 4)
        1:       sender_idle_pct = 65;
        3:       sender_idle_pct = 21;
        default: sender_idle_pct = 0;
      endcase
      n = live_packets();
      queue_random(135, n <= 8);
      drain();
    end

    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && due_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pte_pkg.sv
rtl/core/pheromone_table_engine_top.sv
tb/testbench.sv
